// File: rtl/encoder_period_speed_estimator_assert.svh
// assertion helpers shared by the rtl
`ifndef ENCODER_PERIOD_SPEED_ESTIMATOR_ASSERT_SVH
`define ENCODER_PERIOD_SPEED_ESTIMATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EPSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define EPSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/epse_pkg.sv
`default_nettype none

package epse_pkg;

   localparam int TIME_WIDTH  = 32;
   localparam int SCALE_WIDTH = 40;
   localparam int SPEED_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SPEED_WIDTH-1:0] SPEED_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0]            TIMEOUT_RESET = 32'd100000;

   // item kinds
   localparam logic ACT_EDGE  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // register indexes, taken from address bit 3
   localparam logic REG_SPEED_SCALE = 1'b0;
   localparam logic REG_TIMEOUT     = 1'b1;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;

   typedef struct packed {
      logic        action;
      logic [31:0] now_us;
      logic        a_level;
      logic        b_level;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] speed;
      logic                          direction;
      logic                          stale;
   } rsp_type;

   // query snapshot handed from front to back
   typedef struct packed {
      logic [SCALE_WIDTH-1:0] scale;
      logic [TIME_WIDTH-1:0]  period;
      logic                   backward;
      logic                   stale;
   } job_type;

endpackage

`default_nettype wire

// File: rtl/encoder_period_speed_estimator.sv
// query path: the queue, a divider load, 40 steps of the restoring divider, then
// the output load, which waits for the result channel; a stale query skips the steps
// the bit-serial 40-bit divider takes one query at a time, others wait in the queue;
// edge transactions give no result and are taken every cycle while the queue has room
// reset (synchronous, active high) clears edge state, queue, divider state and output valid;
// speed_scale resets to 0 and timeout_us to 100000
`default_nettype none

module encoder_period_speed_estimator (
   input  logic                                  clock,
   input  logic                                  reset,
   // item channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  epse_pkg::req_type                     req_data,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output epse_pkg::rsp_type                     rsp_data,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [epse_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [epse_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [epse_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import epse_pkg::*;

   // configuration registers
   logic [SCALE_WIDTH-1:0] speed_scale_ff, speed_scale_in;
   logic [31:0]            timeout_ff, timeout_in;
   logic                   csr_write;
   logic                   reg_sel;

   // front to queue to back
   logic    queue_full;
   logic    queue_empty;
   logic    job_push;
   logic    job_pop;
   job_type push_job;
   job_type pop_job;

   // registers sit on 64-bit words, so address bit 3 picks the register
   assign reg_sel    = csr_paddr[3];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      speed_scale_in = speed_scale_ff;
      timeout_in     = timeout_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_SPEED_SCALE: speed_scale_in = csr_pwdata[SCALE_WIDTH-1:0];
            REG_TIMEOUT:     timeout_in     = csr_pwdata[31:0];
            default:         ;
         endcase
      end
   end

   // read mux, registers zero-extended to the bus
   always_comb begin
      unique case (reg_sel)
         REG_SPEED_SCALE: csr_prdata = CSR_DATA_WIDTH'(speed_scale_ff);
         REG_TIMEOUT:     csr_prdata = CSR_DATA_WIDTH'(timeout_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_scale_ff <= '0;
         timeout_ff     <= TIMEOUT_RESET;
      end else begin
         speed_scale_ff <= speed_scale_in;
         timeout_ff     <= timeout_in;
      end
   end

   // front: edge bookkeeping, stale check and query snapshot
   epse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .speed_scale (speed_scale_ff),
      .timeout_us  (timeout_ff),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job_data    (push_job)
   );

   // short queue decouples front from the divider
   epse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .empty     (queue_empty),
      .pop_data  (pop_job)
   );

   // back: serial divide, saturate, sign and output register
   epse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (queue_empty),
      .job_data  (pop_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/epse_front.sv
`default_nettype none

module epse_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  epse_pkg::req_type                   req_data,
   input  logic [epse_pkg::SCALE_WIDTH-1:0]    speed_scale,
   input  logic [31:0]                         timeout_us,
   input  logic                                queue_full,
   output logic                                job_push,
   output epse_pkg::job_type                   job_data
);
   import epse_pkg::*;

   logic [TIME_WIDTH-1:0] last_time_ff, last_time_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in;
   logic                  seen_ff, seen_in;
   logic                  backward_ff, backward_in;
   logic [TIME_WIDTH-1:0] now_time;
   logic [TIME_WIDTH-1:0] age;
   logic                  accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign now_time  = TIME_WIDTH'(req_data.now_us);
   assign age       = now_time - last_time_ff;

   always_comb begin
      last_time_in = last_time_ff;
      period_in    = period_ff;
      seen_in      = seen_ff;
      backward_in  = backward_ff;
      if (accept && (req_data.action == ACT_EDGE)) begin
         last_time_in = now_time;
         seen_in      = 1'b1;
         if (seen_ff) begin
            period_in   = now_time - last_time_ff;
            backward_in = req_data.a_level ^ req_data.b_level;
         end
      end
   end

   assign job_push          = accept && (req_data.action == ACT_QUERY);
   assign job_data.scale    = speed_scale;
   assign job_data.period   = period_ff;
   assign job_data.backward = backward_ff;
   assign job_data.stale    = (period_ff == '0) || (age > timeout_us);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         period_ff    <= '0;
         seen_ff      <= 1'b0;
         backward_ff  <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         period_ff    <= period_in;
         seen_ff      <= seen_in;
         backward_ff  <= backward_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/epse_fifo.sv
`default_nettype none
`include "encoder_period_speed_estimator_assert.svh"

module epse_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  epse_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output epse_pkg::job_type pop_data
);
   import epse_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `EPSE_ASSERT_NOW(a_no_push_full, clock, reset, push, !full || pop, "push into full queue")
   `EPSE_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !empty, "pop from empty queue")
   `EPSE_ASSERT_NEXT(a_fill_tracks, clock, reset, push && !pop && !full, !empty, "queue lost an entry")

endmodule

`default_nettype wire

// File: rtl/epse_back.sv
`default_nettype none
`include "encoder_period_speed_estimator_assert.svh"

module epse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  epse_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output epse_pkg::rsp_type rsp_data
);
   import epse_pkg::*;

   localparam int CNT_W = $clog2(SCALE_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [SCALE_WIDTH-1:0] quot_ff, quot_in;
   logic [TIME_WIDTH-1:0]  rem_ff, rem_in;
   logic [TIME_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [CNT_W-1:0]       step_ff, step_in;
   logic                   backward_ff, backward_in;
   logic                   stale_ff, stale_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [TIME_WIDTH:0]    shifted;
   logic [TIME_WIDTH:0]    trial;
   logic [SPEED_WIDTH-1:0] mag;
   logic                   load_out;

   // one restoring step per cycle
   assign shifted = {rem_ff, quot_ff[SCALE_WIDTH-1]};
   assign trial   = shifted - {1'b0, divisor_ff};

   assign mag = (quot_ff > SCALE_WIDTH'(SPEED_MAX)) ? SPEED_MAX : quot_ff[SPEED_WIDTH-1:0];

   assign job_pop  = (state_ff == ST_IDLE) && !job_empty;
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      step_in     = step_ff;
      backward_in = backward_ff;
      stale_in    = stale_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               backward_in = job_data.backward;
               stale_in    = job_data.stale;
               divisor_in  = job_data.period;
               rem_in      = '0;
               step_in     = CNT_W'(SCALE_WIDTH - 1);
               if (job_data.stale) begin
                  quot_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  quot_in  = job_data.scale;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!trial[TIME_WIDTH]) begin
               rem_in  = trial[TIME_WIDTH-1:0];
               quot_in = {quot_ff[SCALE_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = shifted[TIME_WIDTH-1:0];
               quot_in = {quot_ff[SCALE_WIDTH-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in     = 1'b1;
         rsp_in.direction = backward_ff;
         rsp_in.stale     = stale_ff;
         if (stale_ff) begin
            rsp_in.speed = '0;
         end else if (backward_ff) begin
            rsp_in.speed = ~mag + 1'b1;
         end else begin
            rsp_in.speed = mag;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      step_ff     <= step_in;
      backward_ff <= backward_in;
      stale_ff    <= stale_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `EPSE_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == ST_DIV, divisor_ff != '0, "divide by zero period")
   `EPSE_ASSERT_NEXT(a_out_loaded, clock, reset, load_out, rsp_valid_ff, "result not presented")
   `EPSE_ASSERT_NOW(a_stale_zero, clock, reset, rsp_valid_ff && rsp_ff.stale, rsp_ff.speed == '0, "stale result with speed")

endmodule

`default_nettype wire

// File: bench/tb_encoder_period_speed_estimator.sv
`default_nettype none

module tb_encoder_period_speed_estimator;
   timeunit 1ns;
   timeprecision 1ps;

   import epse_pkg::*;

   // idle time after draining, before any register write
   localparam int SETTLE_CYCLES = 100;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 140;
   // phase that runs with no idling on either side
   localparam int CALM_PHASE    = 2;

   // mirror of the wheel state plus the queue of speeds still owed by the block
   class speed_scoreboard;
      logic [SCALE_WIDTH-1:0] scale;
      logic [31:0]            timeout;
      logic [TIME_WIDTH-1:0]  last_edge;
      logic [TIME_WIDTH-1:0]  period;
      logic                   seen;
      logic                   backward;
      rsp_type                pending_speeds[$];
      int                     mismatches;
      int                     edges;
      int                     queries;
      int                     stale_count;
      int                     saturated;

      function new();
         scale       = '0;
         timeout     = TIMEOUT_RESET;
         last_edge   = '0;
         period      = '0;
         seen        = 1'b0;
         backward    = 1'b0;
         mismatches  = 0;
         edges       = 0;
         queries     = 0;
         stale_count = 0;
         saturated   = 0;
      endfunction

      function void write_reg(logic idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            REG_SPEED_SCALE: scale   = value[SCALE_WIDTH-1:0];
            REG_TIMEOUT:     timeout = value[31:0];
         endcase
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // update the wheel state for an edge, or queue the speed a query must return
      function void note_encoder_item(req_type it);
         logic [TIME_WIDTH-1:0]  age;
         logic [SCALE_WIDTH-1:0] mag;
         rsp_type                r;
         if (it.action == ACT_EDGE) begin
            edges++;
            // first edge only stamps its time
            if (seen) begin
               period   = it.now_us - last_edge;
               backward = (it.a_level != it.b_level);
            end
            last_edge = it.now_us;
            seen      = 1'b1;
         end else begin
            queries++;
            age         = it.now_us - last_edge;
            r.direction = backward;
            if (period == '0 || age > timeout) begin
               r.speed = '0;
               r.stale = 1'b1;
               stale_count++;
            end else begin
               mag = scale / SCALE_WIDTH'(period);
               if (mag > SCALE_WIDTH'(SPEED_MAX)) begin
                  mag = SCALE_WIDTH'(SPEED_MAX);
                  saturated++;
               end
               r.speed = backward ? SPEED_WIDTH'(0) - mag[SPEED_WIDTH-1:0]
                                  : mag[SPEED_WIDTH-1:0];
               r.stale = 1'b0;
            end
            pending_speeds.push_back(r);
         end
      endfunction

      task check_speed(rsp_type got);
         rsp_type want;
         if (pending_speeds.size() == 0) begin
            report($sformatf("result with nothing pending, speed %0d", got.speed));
            return;
         end
         want = pending_speeds.pop_front();
         if (got.speed !== want.speed)
            report($sformatf("speed %0d, expected %0d", got.speed, want.speed));
         if (got.direction !== want.direction)
            report($sformatf("direction %b, expected %b", got.direction, want.direction));
         if (got.stale !== want.stale)
            report($sformatf("stale %b, expected %b", got.stale, want.stale));
      endtask
   endclass

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_type                   req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   speed_scoreboard sb = new();

   // stimulus-side view of time: the last edge timestamp we sent and the current timeout
   logic [31:0] tb_time     = '0;
   logic [31:0] cur_timeout = TIMEOUT_RESET;
   logic        calm        = 1'b0;
   int          setting_count = 0;
   int          cycle_count   = 0;

   encoder_period_speed_estimator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side drops ready at random with a 14 percent chance, never during the calm phase
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 14);
   end

   // every result transaction is checked against the oldest pending speed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_speed(rsp_data);
   end

   // watchdog: a hang anywhere ends the run as a failure
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("watchdog expired after %0d cycles, %0d speeds still pending",
               cycle_count, sb.pending_speeds.size());
      $display("tb_encoder_period_speed_estimator: FAIL");
      $finish;
   end

   // present one transaction, hold it until accepted, then maybe leave a gap
   task send_item(input req_type it);
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_encoder_item(it);
      if (!calm && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task send_edge(input logic [31:0] now, input logic a, input logic b);
      req_type it;
      it.action  = ACT_EDGE;
      it.now_us  = now;
      it.a_level = a;
      it.b_level = b;
      send_item(it);
   endtask

   // levels are don't-care on a query, so they go out random
   task send_query(input logic [31:0] now);
      req_type it;
      it.action  = ACT_QUERY;
      it.now_us  = now;
      it.a_level = 1'($urandom_range(0, 1));
      it.b_level = 1'($urandom_range(0, 1));
      send_item(it);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task csr_write(input logic idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_reg(idx, value);
      if (idx == REG_TIMEOUT)
         cur_timeout = value[31:0];
   endtask

   // apb read, compared with the register width only
   task csr_check(input logic idx);
      logic [CSR_DATA_WIDTH-1:0] want;
      logic [CSR_DATA_WIDTH-1:0] mask;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 3'b000});
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_SPEED_SCALE) begin
         want = CSR_DATA_WIDTH'(sb.scale);
         mask = (CSR_DATA_WIDTH'(1) << SCALE_WIDTH) - CSR_DATA_WIDTH'(1);
      end else begin
         want = CSR_DATA_WIDTH'(sb.timeout);
         mask = CSR_DATA_WIDTH'(32'hFFFF_FFFF);
      end
      if ((csr_prdata & mask) !== want)
         sb.report($sformatf("register %0d reads %h, expected %h", idx, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // both registers, with junk above their widths, then read back
   task set_config(input logic [SCALE_WIDTH-1:0] scale, input logic [31:0] tmo);
      csr_write(REG_SPEED_SCALE, {24'($urandom), scale});
      csr_write(REG_TIMEOUT, {32'($urandom), tmo});
      csr_check(REG_SPEED_SCALE);
      csr_check(REG_TIMEOUT);
      setting_count++;
   endtask

   // wait for every owed speed, then idle for SETTLE_CYCLES before touching registers
   task drain;
      req_valid <= 1'b0;
      while (sb.pending_speeds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly plausible edge/query traffic, some fully random noise
   task run_random_phase(input int count);
      int          pick;
      int          sel;
      logic [31:0] delta;
      logic [31:0] age;
      req_type     it;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 48) begin
            // edge: usually a modest period, sometimes zero, tiny or huge
            sel = $urandom_range(0, 9);
            if (sel < 7)       delta = $urandom_range(1, 4000);
            else if (sel == 7) delta = '0;
            else if (sel == 8) delta = $urandom;
            else               delta = $urandom_range(1, 20);
            tb_time = tb_time + delta;
            send_edge(tb_time, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 90) begin
            // query: fresh, right at the timeout boundary, or anywhere
            sel = $urandom_range(0, 19);
            if (sel < 12)      age = $urandom_range(0, 3000);
            else if (sel < 16) age = cur_timeout + $urandom_range(0, 2) - 1;
            else               age = $urandom;
            send_query(tb_time + age);
         end else begin
            it.action  = 1'($urandom_range(0, 1));
            it.now_us  = $urandom;
            it.a_level = 1'($urandom_range(0, 1));
            it.b_level = 1'($urandom_range(0, 1));
            if (it.action == ACT_EDGE)
               tb_time = it.now_us;
            send_item(it);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset values of both registers
      csr_check(REG_SPEED_SCALE);
      csr_check(REG_TIMEOUT);

      // query before any edge is stale
      send_query(32'd0);
      drain;

      set_config(40'h00_0100_0000, 32'd5000);
      // first edge only records its time, levels say backward but direction stays
      send_edge(32'hFFFF_FF00, 1'b1, 1'b0);
      send_query(32'hFFFF_FF10);
      // timestamp wraps through zero
      send_edge(32'h0000_0100, 1'b0, 1'b0);
      send_query(32'h0000_0100);
      send_edge(32'h0000_0600, 1'b1, 1'b1);
      // age exactly at the timeout, then one past it
      send_query(32'h0000_0600 + 32'd5000);
      send_query(32'h0000_0600 + 32'd5001);
      // backward travel gives a negative speed
      send_edge(32'h0000_0700, 1'b1, 1'b0);
      send_query(32'h0000_0700);
      // an edge at the same time as the last one leaves a zero period
      send_edge(32'h0000_0700, 1'b0, 1'b1);
      send_query(32'h0000_0701);
      send_edge(32'h0000_0701, 1'b0, 1'b1);
      send_query(32'h0000_0701);
      send_query(32'hFFFF_FFFF);
      drain;

      // largest scale over a one-microsecond period saturates both ways
      set_config({SCALE_WIDTH{1'b1}}, 32'hFFFF_FFFF);
      send_query(32'h0000_0000);
      send_edge(32'h0000_0702, 1'b0, 1'b0);
      send_query(32'h0000_0702);
      drain;

      // zero scale and zero timeout
      set_config('0, '0);
      send_query(32'h0000_0702);
      send_query(32'h0000_0703);
      send_edge(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_query(32'hFFFF_FFFF);
      drain;

      tb_time = 32'hFFFF_FFFF;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:          set_config({8'($urandom), 32'($urandom)}, $urandom_range(500, 6000));
            1:          set_config({8'd0, 32'($urandom)}, '0);
            CALM_PHASE: set_config({SCALE_WIDTH{1'b1}}, 32'hFFFF_FFFF);
            3:          set_config('0, $urandom_range(100, 6000));
            default:    set_config({8'($urandom), 32'($urandom)}, $urandom);
         endcase
         calm = (phase == CALM_PHASE);
         run_random_phase(PHASE_ITEMS);
         drain;
         calm = 1'b0;
      end

      if (sb.pending_speeds.size() != 0)
         sb.report($sformatf("%0d speeds never returned", sb.pending_speeds.size()));

      $display("ran %0d edge and %0d query transactions across %0d register settings",
               sb.edges, sb.queries, setting_count);
      $display("%0d stale and %0d saturated speeds predicted, %0d mismatches",
               sb.stale_count, sb.saturated, sb.mismatches);
      if (sb.mismatches == 0)
         $display("tb_encoder_period_speed_estimator: PASS");
      else
         $display("tb_encoder_period_speed_estimator: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/epse_pkg.sv
rtl/epse_front.sv
rtl/epse_fifo.sv
rtl/epse_back.sv
rtl/encoder_period_speed_estimator.sv
bench/tb_encoder_period_speed_estimator.sv
